### rtl/shared_exclusive_lock_arbiter_top_macros.svh
// assertion macros shared by the lock arbiter rtl
// no dependencies; included by modules that carry assertions
`ifndef SHARED_EXCLUSIVE_LOCK_ARBITER_TOP_MACROS_SVH
`define SHARED_EXCLUSIVE_LOCK_ARBITER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SELA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lock arbiter assertion failed");
`define SELA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lock arbiter assertion failed");
`else
`define SELA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SELA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/sela_pkg.sv
// package for the shared/exclusive lock arbiter: widths, codes, control structs
// no dependencies
package sela_pkg;

	localparam int RANK_W      = 10;
	localparam int TAG_W       = 64;
	localparam int HOLD_W      = 12;
	localparam int WAIT_DEPTH  = 16;
	localparam int WAIT_AW     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int WAIT_CW     = $clog2(WAIT_DEPTH + 1);
	localparam int ENTRY_W     = RANK_W + 1 + TAG_W;
	localparam int IN_FIELDS_W = RANK_W + 1 + TAG_W + TAG_W + 1;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = RANK_W + TAG_W + 1;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic signed [HOLD_W-1:0] HOLD_MAX  = 12'sd2047;
	localparam logic signed [HOLD_W-1:0] HOLD_EXCL = -12'sd1;
	localparam logic [WAIT_CW-1:0] WAIT_FULL = WAIT_CW'(WAIT_DEPTH);
	localparam logic [WAIT_AW-1:0] WAIT_LAST = WAIT_AW'(WAIT_DEPTH - 1);

	typedef enum logic [1:0] {
		CMD_LOCK   = 2'd0,
		CMD_UNLOCK = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		RPL_GRANT       = 3'd0,
		RPL_UNLOCK_ACK  = 3'd1,
		RPL_FLUSH_ACK   = 3'd2,
		RPL_WOULD_BLOCK = 3'd3,
		RPL_QUEUE_FULL  = 3'd4,
		RPL_UNLOCK_ERR  = 3'd5
	} reply_t;

	typedef enum logic [1:0] {
		HOLD_KEEP,
		HOLD_TAKE_IN,
		HOLD_TAKE_HEAD,
		HOLD_RELEASE
	} hold_op_t;

	typedef enum logic [1:0] {
		TAG_HANDLE,
		TAG_SERIAL,
		TAG_PEND
	} tag_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DRAIN_RD,
		ST_DRAIN_TAKE,
		ST_DRAIN_WAIT,
		ST_DRAIN_CHK,
		ST_PEND_LAST
	} state_t;

	typedef struct packed {
		logic     in_load;
		logic     emit;
		reply_t   emit_kind;
		tag_sel_t emit_sel;
		logic     emit_last;
		hold_op_t hold_op;
		logic     enq;
		logic     deq;
	} sela_cmd_t;

	typedef struct packed {
		logic [1:0] in_cmd;
		logic       in_pending;
		logic       take_ok;
		logic       q_empty;
		logic       q_full;
		logic       q_last;
		logic       hold_free;
		logic       rel_frees;
		logic       head_fits;
		logic       out_free;
	} sela_status_t;

endpackage

### rtl/sela_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sela_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/sela_dp.sv
// datapath of the lock arbiter: input and output registers, holder count, wait fifo
// depends on sela_pkg, sela_ram and the assertion macro header
`include "shared_exclusive_lock_arbiter_top_macros.svh"
module sela_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [sela_pkg::RANK_W-1:0]   cfg_wr_data,
	input  logic [1:0]                    in_cmd,
	input  logic [sela_pkg::IN_TDATA_W-1:0] in_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [sela_pkg::OUT_TDATA_W-1:0] out_data,
	output logic [2:0]                    out_kind,
	output logic                          out_last,
	input  sela_pkg::sela_cmd_t           cmd,
	output sela_pkg::sela_status_t        status
);
	import sela_pkg::*;

	logic [RANK_W-1:0]        own_rank_q;
	logic [1:0]               in_cmd_q;
	logic [RANK_W-1:0]        in_src_q;
	logic                     in_kind_q;
	logic [TAG_W-1:0]         in_handle_q;
	logic [TAG_W-1:0]         in_serial_q;
	logic                     in_pending_q;
	logic signed [HOLD_W-1:0] holder_q;
	logic signed [HOLD_W-1:0] holder_d;
	logic [WAIT_AW-1:0]       head_q;
	logic [WAIT_AW-1:0]       tail_q;
	logic [WAIT_CW-1:0]       used_q;
	logic [RANK_W-1:0]        pend_rank_q;
	logic [TAG_W-1:0]         pend_handle_q;
	logic                     out_valid_q;
	logic [RANK_W-1:0]        out_rank_q;
	logic [TAG_W-1:0]         out_tag_q;
	logic                     out_local_q;
	reply_t                   out_kind_q;
	logic                     out_last_q;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic                     head_kind;
	logic                     shared_ok;
	logic [RANK_W-1:0]        emit_rank;
	logic [TAG_W-1:0]         emit_tag;

	sela_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(WAIT_DEPTH)
	) u_wait_ram (
		.clk  (clk),
		.we   (cmd.enq),
		.waddr(tail_q),
		.wdata({in_handle_q, in_kind_q, in_src_q}),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	assign head_kind = ram_rdata[RANK_W];
	assign shared_ok = !holder_q[HOLD_W-1] && (holder_q != HOLD_MAX);

	always_comb begin
		status.in_cmd     = in_cmd_q;
		status.in_pending = in_pending_q;
		status.take_ok    = in_kind_q ? (holder_q == '0) : shared_ok;
		status.q_empty    = (used_q == '0);
		status.q_full     = (used_q == WAIT_FULL);
		status.q_last     = (used_q == WAIT_CW'(1));
		status.hold_free  = (holder_q == '0);
		status.rel_frees  = holder_q[HOLD_W-1] || (holder_q == HOLD_W'(1));
		status.head_fits  = head_kind ? (holder_q == '0) : shared_ok;
		status.out_free   = !out_valid_q || out_ready;
	end

	always_comb begin
		unique case (cmd.hold_op)
			HOLD_TAKE_IN:   holder_d = in_kind_q ? HOLD_EXCL : holder_q + HOLD_W'(1);
			HOLD_TAKE_HEAD: holder_d = head_kind ? HOLD_EXCL : holder_q + HOLD_W'(1);
			HOLD_RELEASE:   holder_d = holder_q[HOLD_W-1] ? '0 : holder_q - HOLD_W'(1);
			default:        holder_d = holder_q;
		endcase
	end

	always_comb begin
		unique case (cmd.emit_sel)
			TAG_SERIAL: begin
				emit_rank = in_src_q;
				emit_tag  = in_serial_q;
			end
			TAG_PEND: begin
				emit_rank = pend_rank_q;
				emit_tag  = pend_handle_q;
			end
			default: begin
				emit_rank = in_src_q;
				emit_tag  = in_handle_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_rank_q  <= '0;
			holder_q    <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				own_rank_q <= cfg_wr_data;
			end
			holder_q <= holder_d;
			if (cmd.enq) begin
				tail_q <= (tail_q == WAIT_LAST) ? '0 : tail_q + WAIT_AW'(1);
			end
			if (cmd.deq) begin
				head_q <= (head_q == WAIT_LAST) ? '0 : head_q + WAIT_AW'(1);
			end
			if (cmd.enq && !cmd.deq) begin
				used_q <= used_q + WAIT_CW'(1);
			end else if (cmd.deq && !cmd.enq) begin
				used_q <= used_q - WAIT_CW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			in_cmd_q     <= in_cmd;
			in_src_q     <= in_data[RANK_W-1:0];
			in_kind_q    <= in_data[RANK_W];
			in_handle_q  <= in_data[RANK_W+TAG_W:RANK_W+1];
			in_serial_q  <= in_data[RANK_W+2*TAG_W:RANK_W+TAG_W+1];
			in_pending_q <= in_data[RANK_W+2*TAG_W+1];
		end
		if (cmd.deq) begin
			pend_rank_q   <= ram_rdata[RANK_W-1:0];
			pend_handle_q <= ram_rdata[ENTRY_W-1:RANK_W+1];
		end
		if (cmd.emit) begin
			out_rank_q  <= emit_rank;
			out_tag_q   <= emit_tag;
			out_local_q <= (emit_rank == own_rank_q);
			out_kind_q  <= cmd.emit_kind;
			out_last_q  <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_local_q, out_tag_q, out_rank_q};
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

	`SELA_ASSERT_IMPLY(a_emit_into_free, clk, arst_n, cmd.emit, status.out_free)
	`SELA_ASSERT_IMPLY(a_enq_not_full, clk, arst_n, cmd.enq, !status.q_full)
	`SELA_ASSERT_IMPLY(a_excl_is_minus_one, clk, arst_n, holder_q[HOLD_W-1], holder_q == HOLD_EXCL)
	`SELA_ASSERT_NEXT(a_deq_counts_down, clk, arst_n, cmd.deq && !status.q_empty, used_q == $past(used_q) - WAIT_CW'(1))

endmodule

### rtl/sela_ctrl.sv
// controller state machine of the lock arbiter: sequences evaluation and fifo drain
// depends on sela_pkg
module sela_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sela_pkg::sela_status_t status,
	output sela_pkg::sela_cmd_t    cmd
);
	import sela_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.in_load   = 1'b0;
		cmd.emit      = 1'b0;
		cmd.emit_kind = RPL_GRANT;
		cmd.emit_sel  = TAG_HANDLE;
		cmd.emit_last = 1'b1;
		cmd.hold_op   = HOLD_KEEP;
		cmd.enq       = 1'b0;
		cmd.deq       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_load = in_valid;
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
					case (status.in_cmd)
						CMD_LOCK: begin
							if (status.take_ok) begin
								cmd.emit    = 1'b1;
								cmd.hold_op = HOLD_TAKE_IN;
							end else if (status.q_full) begin
								cmd.emit      = 1'b1;
								cmd.emit_kind = RPL_QUEUE_FULL;
							end else begin
								cmd.enq = 1'b1;
							end
						end
						CMD_UNLOCK: begin
							cmd.emit = 1'b1;
							if (status.in_pending) begin
								cmd.emit_kind = RPL_WOULD_BLOCK;
							end else if (status.hold_free) begin
								cmd.emit_kind = RPL_UNLOCK_ERR;
							end else begin
								cmd.emit_kind = RPL_UNLOCK_ACK;
								cmd.hold_op   = HOLD_RELEASE;
								cmd.emit_last = !(status.rel_frees && !status.q_empty);
								if (status.rel_frees && !status.q_empty) begin
									state_d = ST_DRAIN_RD;
								end
							end
						end
						CMD_FLUSH: begin
							cmd.emit      = 1'b1;
							cmd.emit_sel  = TAG_SERIAL;
							cmd.emit_kind = status.in_pending ? RPL_WOULD_BLOCK : RPL_FLUSH_ACK;
						end
						default: begin
							cmd.emit = 1'b0;
						end
					endcase
				end
			end
			ST_DRAIN_RD: begin
				state_d = ST_DRAIN_TAKE;
			end
			ST_DRAIN_TAKE: begin
				cmd.deq     = 1'b1;
				cmd.hold_op = HOLD_TAKE_HEAD;
				state_d     = status.q_last ? ST_PEND_LAST : ST_DRAIN_WAIT;
			end
			ST_DRAIN_WAIT: begin
				state_d = ST_DRAIN_CHK;
			end
			ST_DRAIN_CHK: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = TAG_PEND;
					cmd.emit_last = !status.head_fits;
					state_d       = status.head_fits ? ST_DRAIN_TAKE : ST_IDLE;
				end
			end
			ST_PEND_LAST: begin
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = TAG_PEND;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/shared_exclusive_lock_arbiter_top.sv
// top level of the shared/exclusive lock arbiter
// depends on sela_pkg, sela_ctrl and sela_dp
// Target-side reader/writer lock for one shared window with a 16-entry wait fifo.
// A transaction is taken when the block is idle; a lock, flush or plain unlock
// is captured, then evaluated against the holder count. An unlock that frees
// the lock drains waiters one at a time through the registered read of the
// wait ram: each waiter is read, taken from the fifo and then granted. Replies
// stall while m_tready holds back the single output register. No clearing
// pass after reset.
module shared_exclusive_lock_arbiter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [sela_pkg::RANK_W-1:0]      cfg_wr_data,  // own_rank
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// source_rank, lock_kind, request_handle, flush_serial, fragments_pending
	input  logic [sela_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [1:0]                       s_tuser,      // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sela_pkg::OUT_TDATA_W-1:0] m_tdata,      // dest_rank, reply_tag, is_local
	output logic [2:0]                       m_tuser,      // reply_kind
	output logic                             m_tlast       // last_reply
);
	import sela_pkg::*;

	sela_cmd_t    cmd;
	sela_status_t status;

	sela_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	sela_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_cmd     (s_tuser),
		.in_data    (s_tdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_data   (m_tdata),
		.out_kind   (m_tuser),
		.out_last   (m_tlast),
		.cmd        (cmd),
		.status     (status)
	);

endmodule
